// File: hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg: shared types and constants for the sorted key search block
// Item layouts, request codes and the control bundles between the search
// controller and its datapath.
// ----------------------------------------------------------------------------
package sks_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 4096;
	localparam int INDEX_W             = 12;
	localparam int KEY_W               = 16;
	localparam int COUNT_W             = 13;

	localparam logic [KEY_W-1:0] RESERVED_KEY_MIN = 16'hFFF1;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [INDEX_W-1:0] entry_index;
		logic [KEY_W-1:0]   entry_key;
		logic [KEY_W-1:0]   lookup_key;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] found_index;
		logic               hit;
	} rsp_t;

	typedef struct packed {
		logic wr_en;
		logic lookup_load;
		logic early_set;
		logic step;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic early_exit;
		logic probe_hit;
		logic search_done;
	} status_t;

endpackage

// File: hdl/sks_datapath.sv
// ----------------------------------------------------------------------------
// sks_datapath: key table, search bounds and result registers
// Holds the key memory with a registered read port, a copy of entry zero,
// the entry count register and the lo/hi/mid bounds of the binary search.
// ----------------------------------------------------------------------------
module sks_datapath #(
	parameter int TABLE_DEPTH = sks_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sks_pkg::COUNT_W-1:0]        cfg_wdata,
	input  sks_pkg::req_t                      req,
	input  sks_pkg::cmd_t                      cmd,
	output sks_pkg::status_t                   status,
	output sks_pkg::rsp_t                      rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = sks_pkg::INDEX_W;

	logic [sks_pkg::KEY_W-1:0]   mem [TABLE_DEPTH];
	logic [sks_pkg::KEY_W-1:0]   rd_data_q;
	logic [sks_pkg::KEY_W-1:0]   entry0_q;
	logic [sks_pkg::KEY_W-1:0]   key_q;
	logic [sks_pkg::COUNT_W-1:0] entry_count_q;
	logic [AW:0]                 lo_q;
	logic [AW-1:0]               hi_q;
	logic [AW-1:0]               mid_q;
	logic [sks_pkg::INDEX_W-1:0] pend_idx_q;
	logic                        pend_hit_q;
	sks_pkg::rsp_t               rsp_q;

	logic          wr_valid;
	logic [AW-1:0] wr_addr;
	logic [31:0]   used;
	logic [AW-1:0] hi_init;
	logic          probe_lt;
	logic          probe_eq;
	logic [AW:0]   lo_n;
	logic [AW-1:0] hi_n;
	logic [AW:0]   lo_sel;
	logic [AW-1:0] hi_sel;
	logic [AW-1:0] diff;
	logic [AW-1:0] rd_addr;

	assign wr_valid = cmd.wr_en && ({20'd0, req.entry_index} < 32'(TABLE_DEPTH));
	assign wr_addr  = AW'(req.entry_index);

	assign used    = ({19'd0, entry_count_q} > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
	                                                             : {19'd0, entry_count_q};
	assign hi_init = AW'(used - 32'd1);

	assign probe_lt = rd_data_q < key_q;
	assign probe_eq = rd_data_q == key_q;
	assign lo_n     = probe_lt ? ({1'b0, mid_q} + (AW+1)'(1)) : lo_q;
	assign hi_n     = probe_lt ? hi_q : (mid_q - AW'(1));

	assign lo_sel  = cmd.step ? lo_n : lo_q;
	assign hi_sel  = cmd.step ? hi_n : hi_q;
	assign diff    = hi_sel - lo_sel[AW-1:0];
	assign rd_addr = lo_sel[AW-1:0] + (diff >> 1);

	assign status.early_exit  = (entry_count_q == '0) || (key_q == entry0_q) ||
	                            (key_q >= sks_pkg::RESERVED_KEY_MIN);
	assign status.probe_hit   = probe_eq;
	assign status.search_done = probe_eq || (!probe_lt && (mid_q == '0)) ||
	                            (lo_n > {1'b0, hi_n});

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem[wr_addr] <= req.entry_key;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		mid_q <= rd_addr;
		if (wr_valid && (wr_addr == '0)) begin
			entry0_q <= req.entry_key;
		end
		if (cmd.lookup_load) begin
			key_q <= req.lookup_key;
			lo_q  <= '0;
			hi_q  <= hi_init;
		end else if (cmd.step) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (cmd.early_set) begin
			pend_idx_q <= '0;
			pend_hit_q <= (entry_count_q != '0) && (key_q == entry0_q);
		end else if (cmd.step) begin
			pend_idx_q <= probe_eq ? IW'(mid_q) : '0;
			pend_hit_q <= probe_eq;
		end
		if (cmd.publish) begin
			rsp_q.found_index <= pend_idx_q;
			rsp_q.hit         <= pend_hit_q;
		end
	end

endmodule

// File: hdl/sks_ctrl.sv
// ----------------------------------------------------------------------------
// sks_ctrl: search sequencer
// Accepts items, steps the datapath through the early checks and the probe
// loop, and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module sks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req_type,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sks_pkg::status_t  status,
	output sks_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PROBE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.wr_en       = accept && (in_req_type == sks_pkg::REQ_WRITE);
		cmd.lookup_load = accept && (in_req_type == sks_pkg::REQ_LOOKUP);
		case (state_q)
			ST_CHECK:  cmd.early_set = status.early_exit;
			ST_PROBE:  cmd.step      = 1'b1;
			ST_FINISH: cmd.publish   = out_free;
			default:   cmd.step      = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.lookup_load) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.early_exit ? ST_FINISH : ST_PROBE;
				end
				ST_PROBE: begin
					if (status.search_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/sorted_key_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_key_binary_search: sorted key table with binary search lookup
// Write items load the key table; lookup items return the matching index.
// ----------------------------------------------------------------------------
// A write item is taken while the block is idle and gives no result. A lookup
// item passes through the early check, then the probe loop, which issues one
// read of the key memory per cycle, and then the finish step; a key that
// matches entry zero, a reserved key of 0xFFF1 or more, or an empty table
// skips the probe loop. A finished lookup waits while the output register
// still holds an unaccepted result. The result waits in an output register,
// and write items are accepted meanwhile. Keys must be loaded in ascending
// order and every entry below entry_count must be written before a lookup.
module sorted_key_binary_search #(
	parameter int TABLE_DEPTH = sks_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sks_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sks_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sks_pkg::rsp_t               out_data
);

	sks_pkg::cmd_t    cmd;
	sks_pkg::status_t status;

	sks_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (in_data.req_type),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	sks_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (in_data),
		.cmd       (cmd),
		.status    (status),
		.rsp       (out_data)
	);

`ifndef SYNTHESIS
	a_miss_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.found_index == '0)
		else $error("miss result carries a nonzero index");

	a_lookup_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.req_type == sks_pkg::REQ_LOOKUP) |=> !in_ready)
		else $error("input taken while a lookup is in progress");

	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a lookup in progress");
`endif

endmodule
